FILE: src/tosc_pkg.sv
package tosc_pkg;

  localparam int PORT_W  = 4;
  localparam int MODE_W  = 3;
  localparam int TIMER_W = 16;

  localparam logic [MODE_W-1:0] MODE_ON      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIMED   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REWRITE = 3'd5;

  localparam logic [TIMER_W-1:0] TIMER_MAX       = 16'hFFFF;
  localparam logic [TIMER_W-1:0] TIMER_THRESHOLD = 16'd40;
  localparam logic [TIMER_W-1:0] TIMER_STEP_LOW  = 16'd10;
  localparam logic [TIMER_W-1:0] TIMER_STEP_HIGH = 16'd60;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PORT_W-1:0] port;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
    logic              level;
  } report_t;

endpackage

FILE: src/tosc_cmd_if.sv
interface tosc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tosc_pkg::MODE_W-1:0] mode;
  logic [tosc_pkg::PORT_W-1:0] port;

  modport source (output valid, output mode, output port, input ready);
  modport sink (input valid, input mode, input port, output ready);
endinterface

FILE: src/tosc_report_if.sv
interface tosc_report_if;
  logic                          valid;
  logic                          ready;
  logic [tosc_pkg::PORT_W-1:0] report_port;
  logic                          report_level;

  modport source (output valid, output report_port, output report_level, input ready);
  modport sink (input valid, input report_port, input report_level, output ready);
endinterface

FILE: src/tosc_update.sv
module tosc_update #(
  parameter int PORT_COUNT = 16,
  parameter int FIRST_PORT = 1,
  parameter int LAST_PORT  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tosc_pkg::cmd_t    cmd,
  output tosc_pkg::report_t result
);

  // Only ports reachable by a 4-bit index need storage.
  localparam int SLOTS  = (PORT_COUNT < (1 << tosc_pkg::PORT_W)) ? PORT_COUNT
                                                                   : (1 << tosc_pkg::PORT_W);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMP_W  = 10;

  logic [SLOTS-1:0]                levels, levels_next;
  logic [tosc_pkg::TIMER_W-1:0]  remaining, remaining_next;
  logic [tosc_pkg::PORT_W-1:0]   timed_port, timed_port_next;
  logic                            running, running_next;

  logic [CMP_W-1:0]                port_ext, timed_ext;
  logic                            in_range;
  logic [SLOT_W-1:0]               slot, timed_slot;
  logic                            cur_level, new_level;
  logic [tosc_pkg::TIMER_W-1:0]  step_add, dec;
  logic [tosc_pkg::TIMER_W:0]    sum;

  always_comb begin
    port_ext   = CMP_W'(cmd.port);
    timed_ext  = CMP_W'(timed_port);
    in_range   = (port_ext >= CMP_W'(FIRST_PORT)) && (port_ext <= CMP_W'(LAST_PORT)) &&
                 (port_ext < CMP_W'(PORT_COUNT));
    slot       = cmd.port[SLOT_W-1:0];
    timed_slot = timed_port[SLOT_W-1:0];
    cur_level  = levels[slot];

    step_add = (remaining < tosc_pkg::TIMER_THRESHOLD) ? tosc_pkg::TIMER_STEP_LOW
                                                         : tosc_pkg::TIMER_STEP_HIGH;
    sum      = {1'b0, remaining} + {1'b0, step_add};
    dec      = (remaining != '0) ? remaining - 1'b1 : remaining;

    levels_next     = levels;
    remaining_next  = remaining;
    timed_port_next = timed_port;
    running_next    = running;
    new_level       = cur_level;
    result          = '0;

    if (cmd.mode == tosc_pkg::MODE_TICK) begin
      if (running) begin
        remaining_next = dec;
        if (dec == '0) begin
          // expire: switch the timed port off and release the timer
          if (timed_ext < CMP_W'(PORT_COUNT)) begin
            levels_next[timed_slot] = 1'b0;
          end
          timed_port_next = '0;
          running_next    = 1'b0;
          result.valid    = 1'b1;
          result.port     = timed_port;
          result.level    = 1'b0;
        end
      end
    end else if (in_range) begin
      case (cmd.mode)
        tosc_pkg::MODE_ON: new_level = 1'b1;
        tosc_pkg::MODE_OFF: begin
          new_level = 1'b0;
          if (cmd.port == timed_port) begin
            remaining_next  = '0;
            timed_port_next = '0;
            running_next    = 1'b0;
          end
        end
        tosc_pkg::MODE_TOGGLE: new_level = ~cur_level;
        tosc_pkg::MODE_TIMED: begin
          new_level = 1'b1;
          if (!running) begin
            running_next    = 1'b1;
            timed_port_next = cmd.port;
          end
          remaining_next = sum[tosc_pkg::TIMER_W] ? tosc_pkg::TIMER_MAX
                                                  : sum[tosc_pkg::TIMER_W-1:0];
        end
        default: new_level = cur_level;
      endcase
      levels_next[slot] = new_level;
      result.valid      = 1'b1;
      result.port       = cmd.port;
      result.level      = new_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels     <= '0;
      remaining  <= '0;
      timed_port <= '0;
      running    <= 1'b0;
    end else if (step) begin
      levels     <= levels_next;
      remaining  <= remaining_next;
      timed_port <= timed_port_next;
      running    <= running_next;
    end
  end

endmodule

FILE: src/timed_output_switch_controller.sv
// A command beat is held in the input register, and its report beat then in the report register.
// Throughput: one item per cycle; the input register refills while the report
// register is taken, and only a stalled report register holds the input side.
// Items that produce no report pass through the same two stages silently.
// Reset (rst, synchronous): all outputs off, timer idle at zero, both stages empty.
module timed_output_switch_controller #(
  parameter int PORT_COUNT = 16,
  parameter int FIRST_PORT = 1,
  parameter int LAST_PORT  = 8
) (
  input  logic  clk,
  input  logic  rst,
  tosc_cmd_if.sink      cmd,
  tosc_report_if.source report
);

  logic              in_valid;
  tosc_pkg::cmd_t    in_cmd;
  logic              advance;
  tosc_pkg::report_t result;
  logic              out_valid;
  logic [tosc_pkg::PORT_W-1:0] out_port;
  logic              out_level;

  // advance the input stage whenever the report register can take a beat
  assign advance   = !out_valid || report.ready;
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_cmd.mode <= cmd.mode;
      in_cmd.port <= cmd.port;
    end
  end

  tosc_update #(
    .PORT_COUNT(PORT_COUNT),
    .FIRST_PORT(FIRST_PORT),
    .LAST_PORT (LAST_PORT)
  ) u_update (
    .clk   (clk),
    .rst   (rst),
    .step  (in_valid && advance),
    .cmd   (in_cmd),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && result.valid) begin
      out_port  <= result.port;
      out_level <= result.level;
    end
  end

  assign report.valid        = out_valid;
  assign report.report_port  = out_port;
  assign report.report_level = out_level;

endmodule
